// ----- rtl/inverse_erf_of_ratio_unit_defines.svh -----
// assertion macros for the inverse erf of ratio unit
`ifndef INVERSE_ERF_OF_RATIO_UNIT_DEFINES_SVH
`define INVERSE_ERF_OF_RATIO_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IER_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IER_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ierf_pkg.sv -----
// shared widths, constants and stage payload types for the inverse erf unit
package ierf_pkg;
  localparam int unsigned InWidth         = 13;
  localparam int unsigned OutWidth        = 16;
  localparam int unsigned RatioBitsDef    = 12;
  localparam int unsigned OutFracBitsDef  = 12;
  localparam int unsigned XBits           = 16;
  localparam int unsigned LogSteps        = 24;
  // numeric constants in Q24
  localparam logic [23:0] Ln2Q24  = 24'd11629080;
  localparam logic [26:0] CQ24    = 27'd72657874;
  localparam logic [26:0] InvaQ24 = 27'd114130721;

  // item sideband that rides the pipeline beside the data
  typedef struct packed {
    logic neg;
    logic inv;
  } side_t;
endpackage

// ----- rtl/ierf_if.sv -----
// valid/ready stream interface for the ratio and result channels
interface ierf_if #(
  parameter int unsigned W = 26
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ierf_div.sv -----
// pipelined restoring divider: quotient of magnitudes, one quotient bit per stage
module ierf_div
  import ierf_pkg::*;
#(
  parameter int unsigned RatioBits = RatioBitsDef
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RatioBits:0]   num_i,
  input  logic [RatioBits:0]   den_i,
  output logic [XBits-1:0]     quo_o
);
  localparam int unsigned NW = RatioBits + 1;
  // partial remainders, divisors and quotient bits per stage
  logic [NW:0]       rem_r [XBits+1];
  logic [NW-1:0]     den_r [XBits+1];
  logic [XBits-1:0]  q_r   [XBits+1];

  always_comb begin
    rem_r[0] = {1'b0, num_i};
    den_r[0] = den_i;
    q_r[0]   = '0;
  end

  for (genvar g = 0; g < XBits; g++) begin : g_stage
    logic [NW+1:0] sh;
    logic [NW+1:0] df;
    assign sh = {rem_r[g], 1'b0};
    assign df = sh - {2'b00, den_r[g]};
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g+1] <= den_r[g];
        if (!df[NW+1]) begin
          rem_r[g+1] <= df[NW:0];
          q_r[g+1]   <= {q_r[g][XBits-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= sh[NW:0];
          q_r[g+1]   <= {q_r[g][XBits-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = q_r[XBits];
endmodule

// ----- rtl/ierf_log.sv -----
// pipelined -log2 in Q24 by repeated squaring, one result bit per stage
module ierf_log
  import ierf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] u_i,
  output logic [29:0] nlg_o
);
  // stage 0: leading one and normalize to Q30
  logic [5:0]  k_c;
  logic [30:0] m_c;
  logic [5:0]  k_r [LogSteps+1];
  logic [31:0] m_r [LogSteps+1];
  logic [23:0] f_r [LogSteps+1];

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 33; i++) begin
      if (u_i[i]) k_c = 6'(i);
    end
    if (k_c > 6'd30) m_c = 31'(u_i >> (k_c - 6'd30));
    else m_c = 31'(u_i << (6'd30 - k_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0] <= (k_c > 6'd32) ? 6'd32 : k_c;
      m_r[0] <= {1'b0, m_c};
      f_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < LogSteps; g++) begin : g_sq
    logic [63:0] sq;
    logic [33:0] sh;
    assign sq = 64'(m_r[g]) * 64'(m_r[g]);
    assign sh = sq[63:30];
    always_ff @(posedge clk) begin
      if (en) begin
        k_r[g+1] <= k_r[g];
        if (sh[31]) begin
          m_r[g+1] <= sh[32:1];
          f_r[g+1] <= {f_r[g][22:0], 1'b1};
        end else begin
          m_r[g+1] <= sh[31:0];
          f_r[g+1] <= {f_r[g][22:0], 1'b0};
        end
      end
    end
  end

  assign nlg_o = {6'd32 - k_r[LogSteps], 24'd0} - {6'd0, f_r[LogSteps]};
endmodule

// ----- rtl/ierf_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module ierf_sqrt #(
  parameter int unsigned VW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [VW-1:0]   v_i,
  output logic [VW/2-1:0] r_o
);
  localparam int unsigned RW = VW / 2;
  logic [VW-1:0] v_r [RW+1];
  logic [RW+1:0] rem_r [RW+1];
  logic [RW-1:0] r_r [RW+1];

  always_comb begin
    v_r[0]   = v_i;
    rem_r[0] = '0;
    r_r[0]   = '0;
  end

  for (genvar g = 0; g < RW; g++) begin : g_bit
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    assign cur   = {rem_r[g][RW-1:0], v_r[g][VW-1:VW-2]};
    assign trial = {r_r[g], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1] <= {v_r[g][VW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_r[g+1] <= cur - trial;
          r_r[g+1]   <= {r_r[g][RW-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= cur;
          r_r[g+1]   <= {r_r[g][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign r_o = r_r[RW];
endmodule

// ----- rtl/inverse_erf_of_ratio_unit.sv -----
// top level: pipelined inverse erf of a signed ratio
//  channel | dir | beat payload
//  in_     | in  | numer[12:0] signed, denom[12:0] signed
//  out_    | out | value[15:0] signed, invalid
// one beat per cycle sustained while out is not stalled; a beat taken on in is
// offered on out after passing the register stages (16 divider, 1 square, 25 log, 4 glue,
// 32 root, 1 shift, 32 root and 1 output stage)
// the whole pipeline advances together; when out is stalled it holds
// synchronous active-low reset clears all valid bits
module inverse_erf_of_ratio_unit
  import ierf_pkg::*;
#(
  parameter int unsigned RATIO_BITS    = RatioBitsDef,
  parameter int unsigned OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic   clk,
  input  logic   rst_n,
  ierf_if.sink   in_ch,
  ierf_if.source out_ch
);
`include "inverse_erf_of_ratio_unit_defines.svh"
  localparam int unsigned RB = RATIO_BITS;
  localparam int Sh = 2 * int'(OUT_FRAC_BITS) - 24;
  localparam int unsigned Lat = XBits + 1 + 1 + LogSteps + 1 + 1 + 1 + 1 + 32 + 1 + 32 + 1;

  logic en;
  logic [Lat-1:0] vld_r;
  side_t side_r [Lat];

  // output register stage is the last slot; stall freezes everything
  assign en = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;

  logic signed [12:0] p_c, q_c;
  logic [12:0] mp_c, mq_c;
  logic [RB:0] mpc_c, mqc_c;
  assign p_c  = in_ch.data[25:13];
  assign q_c  = in_ch.data[12:0];
  assign mp_c = p_c[12] ? 13'(-p_c) : 13'(p_c);
  assign mq_c = q_c[12] ? 13'(-q_c) : 13'(q_c);
  assign mpc_c = (32'(mp_c) > (32'd1 << RB)) ? (RB+1)'(1 << RB) : (RB+1)'(mp_c);
  assign mqc_c = (32'(mq_c) > (32'd1 << RB)) ? (RB+1)'(1 << RB) : (RB+1)'(mq_c);

  side_t side_c;
  assign side_c.neg = p_c[12] ^ q_c[12];
  assign side_c.inv = (mq_c == 13'd0) || (mp_c >= mq_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_c;
      for (int i = 1; i < Lat; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic [XBits-1:0] x_c;
  ierf_div #(.RatioBits(RB)) u_div (
    .clk(clk), .en(en), .num_i(mpc_c), .den_i(mqc_c), .quo_o(x_c));

  // square and complement: u = 2^32 - x^2 (x already < 2^16)
  logic [32:0] u_r;
  always_ff @(posedge clk) begin
    if (en) u_r <= 33'h1_0000_0000 - 33'(32'(x_c) * 32'(x_c));
  end

  logic [29:0] nlg_c;
  ierf_log u_log (.clk(clk), .en(en), .u_i(u_r), .nlg_o(nlg_c));

  // NL = round(nlg * ln2)
  logic [53:0] prod_r;
  logic [29:0] nl_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 54'(nlg_c) * 54'(Ln2Q24);
      nl_r   <= 30'((prod_r + 54'(1 << 23)) >> 24);
    end
  end

  // t and v
  logic signed [31:0] t_c;
  logic [31:0] tm_c;
  logic [63:0] tsq_r, nli_r;
  logic signed [31:0] t_r, t2_r;
  assign t_c  = 32'(CQ24) - 32'(nl_r >> 1);
  assign tm_c = t_c[31] ? 32'(-t_c) : 32'(t_c);
  always_ff @(posedge clk) begin
    if (en) begin
      tsq_r <= 64'(tm_c) * 64'(tm_c);
      nli_r <= 64'(nl_r) * 64'(InvaQ24);
      t_r   <= t_c;
    end
  end
  logic [63:0] v_r;
  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= tsq_r + nli_r;
      t2_r <= t_r;
    end
  end

  logic [31:0] s_c;
  ierf_sqrt #(.VW(64)) u_sq1 (.clk(clk), .en(en), .v_i(v_r), .r_o(s_c));
  logic signed [31:0] td_r [32];
  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0] <= t2_r;
      for (int i = 1; i < 32; i++) td_r[i] <= td_r[i-1];
    end
  end

  logic signed [33:0] ws_c;
  logic [31:0] w_c;
  logic [63:0] ww_r;
  assign ws_c = $signed({2'b00, s_c}) - 34'(td_r[31]);
  assign w_c  = ws_c[33] ? 32'd0 : 32'(ws_c);
  always_ff @(posedge clk) begin
    if (en) begin
      if (Sh >= 0) ww_r <= 64'(w_c) << Sh;
      else ww_r <= 64'(w_c) >> (-Sh);
    end
  end

  logic [31:0] mag_c;
  ierf_sqrt #(.VW(64)) u_sq2 (.clk(clk), .en(en), .v_i(ww_r), .r_o(mag_c));

  logic [15:0] val_c;
  side_t so_c;
  assign so_c = side_r[Lat-2];
  always_comb begin
    if (so_c.inv) val_c = '0;
    else if (so_c.neg) val_c = (mag_c > 32'd32768) ? 16'h8000 : 16'(-mag_c);
    else val_c = (mag_c > 32'd32767) ? 16'h7fff : mag_c[15:0];
  end
  logic [16:0] out_r;
  always_ff @(posedge clk) begin
    if (en) out_r <= {val_c, so_c.inv};
  end

  assign out_ch.valid = vld_r[Lat-1];
  assign out_ch.data  = out_r;

  `IER_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.data))
  `IER_ASSERT_IMPL(a_inv_zero, clk, rst_n, out_ch.valid && out_ch.data[0], out_ch.data[16:1] == 16'd0)
  `IER_ASSERT_IMPL(a_ready, clk, rst_n, !out_ch.valid, in_ch.ready)
endmodule

// ----- sim/inverse_erf_of_ratio_unit_tb.sv -----
// testbench for the inverse erf of ratio unit: random and corner ratios against a scoreboard
`timescale 1ns / 1ps

module inverse_erf_of_ratio_unit_tb;
  import ierf_pkg::*;

  localparam int unsigned RatioBits   = RatioBitsDef;
  localparam int unsigned OutFracBits = OutFracBitsDef;
  localparam int unsigned NumRandom   = 1000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned IdleLimit   = 6000;

  typedef struct packed {
    logic signed [OutWidth-1:0] value;
    logic                       invalid;
  } erf_result_t;

  class erf_scoreboard;
    erf_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned invalid_seen;
    int unsigned neg_seen;

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // -log2(u / 2^32) in q24
    function automatic longint unsigned neg_log2(longint unsigned u);
      int unsigned k;
      longint unsigned m;
      longint unsigned frac;
      k = 0;
      frac = 0;
      if (u == 0) u = 1;
      while (k < 63 && (u >> (k + 1)) != 0) k++;
      if (k > 30) m = u >> (k - 30);
      else m = u << (30 - k);
      for (int i = 0; i < LogSteps; i++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      if (k > 32) k = 32;
      return (longint'(32 - k) << 24) - frac;
    endfunction

    function automatic erf_result_t inverse_erf(logic signed [InWidth-1:0] numer,
                                                logic signed [InWidth-1:0] denom);
      erf_result_t res;
      longint unsigned mp, mq, cap, x16, u, nl, tmag, v, s, w, mag;
      longint signed t, ws;
      int sh;
      logic neg;
      mp = (numer < 0) ? -longint'(numer) : longint'(numer);
      mq = (denom < 0) ? -longint'(denom) : longint'(denom);
      cap = 64'd1 << RatioBits;
      neg = (numer < 0) != (denom < 0);
      res.value = '0;
      res.invalid = 1'b0;
      if (mq == 0 || mp >= mq) begin
        res.invalid = 1'b1;
        return res;
      end
      if (mp > cap) mp = cap;
      if (mq > cap) mq = cap;
      x16 = (mp << 16) / mq;
      if (x16 > 65535) x16 = 65535;
      u = (64'd1 << 32) - x16 * x16;
      nl = (neg_log2(u) * 64'(Ln2Q24) + (64'd1 << 23)) >> 24;
      t = longint'(CQ24) - longint'(nl >> 1);
      tmag = (t < 0) ? -t : t;
      v = tmag * tmag + nl * 64'(InvaQ24);
      s = int_sqrt(v);
      ws = longint'(s) - t;
      w = (ws > 0) ? ws : 0;
      sh = 2 * OutFracBits - 24;
      if (sh >= 0) w <<= sh;
      else w >>= -sh;
      mag = int_sqrt(w);
      if (neg) res.value = (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
      else res.value = (mag > 32767) ? 16'sd32767 : 16'(mag);
      return res;
    endfunction

    function void note_ratio(logic signed [InWidth-1:0] numer,
                             logic signed [InWidth-1:0] denom);
      pending.insert(pending.size(), inverse_erf(numer, denom));
    endfunction

    function void check_result(erf_result_t got);
      erf_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d invalid=%0b", $time, got.value,
                 got.invalid);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.invalid) invalid_seen++;
      if (exp_r.value < 0) neg_seen++;
      if (got.value !== exp_r.value) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, exp_r.value,
                 got.value);
        errors++;
      end
      if (got.invalid !== exp_r.invalid) begin
        $display("%0t: invalid mismatch expected %0b actual %0b", $time, exp_r.invalid,
                 got.invalid);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  erf_scoreboard sb;

  ierf_if #(.W(2 * InWidth)) in_ch (.clk(clk));
  ierf_if #(.W(OutWidth + 1)) out_ch (.clk(clk));

  inverse_erf_of_ratio_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beats are decided at the falling edge before the rising edge that takes them
  logic in_fire, out_fire;
  logic [2*InWidth-1:0] in_beat;
  erf_result_t out_beat;
  int unsigned idle_cycles;

  always @(negedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    in_beat = in_ch.data;
    out_beat = out_ch.data;
  end

  always @(posedge clk) begin
    if (in_fire) sb.note_ratio(in_beat[2*InWidth-1:InWidth], in_beat[InWidth-1:0]);
    if (out_fire) sb.check_result(out_beat);
    if (in_fire || out_fire || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // result side stalls
  always @(posedge clk) begin
    int unsigned n;
    if (rst_n) begin
      if ($urandom_range(0, 9) < 7) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
      n = gap_len();
      if (n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_ratio(logic signed [InWidth-1:0] numer,
                            logic signed [InWidth-1:0] denom, bit no_gap);
    int unsigned n;
    n = no_gap ? 0 : gap_len();
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {numer, denom};
    do begin
      @(negedge clk);
      @(posedge clk);
    end while (!in_fire);
  endtask

  task automatic send_random(bit no_gap);
    logic signed [InWidth-1:0] p, q;
    int mag_q;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      // well formed ratio below one
      mag_q = (r < 20) ? $urandom_range(4000, 4095) : $urandom_range(1, 4095);
      p = (r < 10) ? 13'(mag_q - int'($urandom_range(1, 3 < mag_q ? 3 : mag_q)))
                   : 13'($urandom_range(0, mag_q - 1));
      if (r < 5 && mag_q > 1) p = 13'(mag_q - 1);
      q = 13'(mag_q);
      if ($urandom_range(0, 1)) p = -p;
      if ($urandom_range(0, 1)) q = -q;
    end else begin
      p = 13'($urandom());
      q = (r < 80) ? 13'sd0 : 13'($urandom());
    end
    send_ratio(p, q, no_gap);
  endtask

  initial begin
    bit burst;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_ratio(13'sd0, 13'sd5, 0);
    send_ratio(13'sd0, -13'sd4095, 0);
    send_ratio(13'sd1, 13'sd0, 0);
    send_ratio(13'sd0, 13'sd0, 0);
    send_ratio(13'sd7, 13'sd7, 0);
    send_ratio(-13'sd9, 13'sd3, 0);
    send_ratio(13'sd4095, 13'sd4095, 0);
    send_ratio(13'sd4094, 13'sd4095, 0);
    send_ratio(-13'sd4094, 13'sd4095, 1);
    send_ratio(13'sd4094, -13'sd4095, 1);
    send_ratio(-13'sd4094, -13'sd4095, 1);
    send_ratio(13'sd1, 13'sd4095, 0);
    send_ratio(-13'sd1, 13'sd4095, 0);
    send_ratio(13'sd1, 13'sd2, 0);
    send_ratio(-13'sd1, -13'sd2, 0);
    send_ratio(13'sd4095, -13'sd4096, 0);
    send_ratio(-13'sd4096, 13'sd4095, 0);
    send_ratio(13'sd4000, -13'sd4096, 0);
    send_ratio(-13'sd4096, -13'sd4096, 0);
    send_ratio(13'sd2047, 13'sd2048, 0);
    send_ratio(13'sd1, -13'sd1, 0);

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
      send_random(burst);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d results: %0d invalid ratios, %0d negative values", sb.checked,
             sb.invalid_seen, sb.neg_seen);
    $display("corner ratios, both signs, zero and near-one ratios, random stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
